FILE: rtl/rmts_pkg.sv
// Shared types and constants for the rate-monotonic tick scheduler.
package rmts_pkg;

	localparam int MAX_SLOTS_DEF = 16;
	localparam int TIME_W        = 32;
	localparam int DATA_W        = 16;
	localparam int CFG_W         = 5;
	localparam int TASK_W        = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] exec_time;
		logic [DATA_W-1:0] period;
		logic [DATA_W-1:0] remaining;
		logic [TIME_W-1:0] next_arrival;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} tbl_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] tick_time;
		logic              ran;
		logic [TASK_W-1:0] task_number;
		logic              completed;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/rmts_table.sv
// Task table memory: one write port, one registered read port.
module rmts_table #(
	parameter int MAX_SLOTS = rmts_pkg::MAX_SLOTS_DEF,
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic               clk,
	input  rmts_pkg::tbl_ctl_t ctl,
	input  logic [SLOT_W-1:0]  wr_addr,
	input  rmts_pkg::entry_t   wr_data,
	input  logic [SLOT_W-1:0]  rd_addr,
	output rmts_pkg::entry_t   rd_data
);
	import rmts_pkg::*;

	entry_t mem_q [MAX_SLOTS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/rmts_cmp.sv
// Compare unit: is the slot ready and better than the current pick.
module rmts_cmp (
	input  rmts_pkg::entry_t                    entry,
	input  logic [rmts_pkg::TIME_W-1:0]         cur_time,
	input  logic                                found,
	input  logic [rmts_pkg::DATA_W-1:0]         best_period,
	output logic                                take
);
	import rmts_pkg::*;

	logic ready;

	assign ready = (entry.next_arrival <= cur_time) && (entry.remaining != '0);
	assign take  = ready && (!found || (entry.period < best_period));

endmodule

FILE: rtl/rmts_seq.sv
// Scan sequencer: loads slots, scans the table one slot per cycle, updates the pick and writes it back.
module rmts_seq #(
	parameter int MAX_SLOTS = rmts_pkg::MAX_SLOTS_DEF,
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          operation,
	input  logic [3:0]                    slot,
	input  logic [rmts_pkg::DATA_W-1:0]   exec_time,
	input  logic [rmts_pkg::DATA_W-1:0]   period,
	input  logic [rmts_pkg::DATA_W-1:0]   first_arrival,
	input  logic [CNT_W-1:0]              n_eff,
	output rmts_pkg::tbl_ctl_t            tbl_ctl,
	output logic [SLOT_W-1:0]             wr_addr,
	output rmts_pkg::entry_t              wr_data,
	output logic [SLOT_W-1:0]             rd_addr,
	input  rmts_pkg::entry_t              rd_data,
	output logic                          busy,
	output rmts_pkg::res_t                res
);
	import rmts_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    idx_q;
	logic                rd_valid_s1;
	logic [SLOT_W-1:0]   rd_idx_s1;
	logic                found_q;
	logic [SLOT_W-1:0]   best_idx_q;
	entry_t              best_q;
	logic [TIME_W-1:0]   time_q;

	logic                issue;
	logic                take;
	logic                slot_ok;
	logic [DATA_W-1:0]   rem_dec;
	logic                fin;
	logic [TIME_W:0]     arr_sum;
	logic [TIME_W-1:0]   arr_next;
	logic [TIME_W-1:0]   time_inc;

	rmts_cmp u_cmp (
		.entry       (rd_data),
		.cur_time    (time_q),
		.found       (found_q),
		.best_period (best_q.period),
		.take        (take)
	);

	assign issue    = (state_q == ST_SCAN) && (idx_q < n_eff);
	assign slot_ok  = 32'(slot) < 32'(MAX_SLOTS);
	assign rem_dec  = best_q.remaining - DATA_W'(1);
	assign fin      = (rem_dec == '0);
	assign arr_sum  = {1'b0, time_q} + (TIME_W + 1)'(best_q.period);
	assign arr_next = arr_sum[TIME_W] ? TIME_MAX : arr_sum[TIME_W-1:0];
	assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tbl_ctl           = '0;
		wr_addr           = SLOT_W'(slot);
		wr_data.exec_time    = exec_time;
		wr_data.period       = period;
		wr_data.remaining    = exec_time;
		wr_data.next_arrival = TIME_W'(first_arrival);
		rd_addr           = idx_q[SLOT_W-1:0];
		busy              = 1'b1;
		res               = '0;
		res.tick_time     = time_q;
		case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				tbl_ctl.wr_en = accept && (operation == OP_LOAD) && slot_ok;
			end
			ST_SCAN: begin
				tbl_ctl.rd_en = issue;
			end
			ST_FINISH: begin
				tbl_ctl.wr_en        = found_q;
				wr_addr              = best_idx_q;
				wr_data.exec_time    = best_q.exec_time;
				wr_data.period       = best_q.period;
				wr_data.remaining    = fin ? best_q.exec_time : rem_dec;
				wr_data.next_arrival = fin ? arr_next : best_q.next_arrival;
				res.valid            = 1'b1;
				res.ran              = found_q;
				res.task_number      = found_q ? TASK_W'(32'(best_idx_q) + 32'd1) : '0;
				res.completed        = found_q && fin;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			time_q      <= '0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (state_q == ST_IDLE && accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (rd_valid_s1 && take) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_FINISH) begin
				time_q <= time_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[SLOT_W-1:0];
		if (rd_valid_s1 && take) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_data;
		end
	end

endmodule

FILE: rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler top level: config register, output register, table, sequencer.
// A load item is taken while busy stays low. A tick item holds busy high while the sequencer,
// with n = min(task_count, MAX_SLOTS), scans n slots one slot per cycle through the single
// read port of the task table and then writes back the picked slot, if any. The result
// shows on the output ports, marked by strobe, for one cycle right after busy falls; it cannot
// be held off, so the receiver must take it in that cycle. A new item may start in that same
// cycle. The task table has no reset: every slot below task_count must be loaded before a tick.
module rate_monotonic_tick_scheduler #(
	parameter int MAX_SLOTS = rmts_pkg::MAX_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [3:0]                   slot,
	input  logic [rmts_pkg::DATA_W-1:0]  exec_time,
	input  logic [rmts_pkg::DATA_W-1:0]  period,
	input  logic [rmts_pkg::DATA_W-1:0]  first_arrival,
	input  logic                         cfg_we,
	input  logic [rmts_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                         strobe,
	output logic [rmts_pkg::TIME_W-1:0]  tick_time,
	output logic                         ran,
	output logic [rmts_pkg::TASK_W-1:0]  task_number,
	output logic                         completed
);
	import rmts_pkg::*;

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

	logic [CFG_W-1:0]  task_count_q;
	logic [CNT_W-1:0]  n_eff;
	logic              accept;
	tbl_ctl_t          tbl_ctl;
	logic [SLOT_W-1:0] wr_addr;
	logic [SLOT_W-1:0] rd_addr;
	entry_t            wr_data;
	entry_t            rd_data;
	res_t              res;

	logic              strobe_q;
	logic [TIME_W-1:0] tick_time_q;
	logic              ran_q;
	logic [TASK_W-1:0] task_number_q;
	logic              completed_q;

	assign accept = start && !busy;
	assign n_eff  = (32'(task_count_q) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
	                                                      : CNT_W'(task_count_q);

	rmts_table #(.MAX_SLOTS(MAX_SLOTS)) u_table (
		.clk     (clk),
		.ctl     (tbl_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rmts_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.operation     (operation),
		.slot          (slot),
		.exec_time     (exec_time),
		.period        (period),
		.first_arrival (first_arrival),
		.n_eff         (n_eff),
		.tbl_ctl       (tbl_ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.busy          (busy),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= res.valid;
			if (cfg_we) begin
				task_count_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			tick_time_q   <= res.tick_time;
			ran_q         <= res.ran;
			task_number_q <= res.task_number;
			completed_q   <= res.completed;
		end
	end

	assign strobe      = strobe_q;
	assign tick_time   = tick_time_q;
	assign ran         = ran_q;
	assign task_number = task_number_q;
	assign completed   = completed_q;

endmodule

FILE: rtl/rmts_checker.sv
// Port-level checks for the rate-monotonic tick scheduler, bound to the top level.
module rmts_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         operation,
	input logic                         strobe,
	input logic                         ran,
	input logic [rmts_pkg::TASK_W-1:0]  task_number,
	input logic                         completed
);
	import rmts_pkg::*;

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while busy");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !ran) |-> (task_number == '0 && !completed))
		else $error("idle tick reports a task");

	a_ran_result: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && ran) |-> (task_number != '0))
		else $error("tick ran without a task number");

	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_LOAD) |=> (!busy && !strobe))
		else $error("load item occupied the block or gave a result");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_TICK) |=> busy)
		else $error("tick item not taken up");

endmodule

bind rate_monotonic_tick_scheduler rmts_checker u_rmts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.operation   (operation),
	.strobe      (strobe),
	.ran         (ran),
	.task_number (task_number),
	.completed   (completed)
);
